FILE: design/htm_pkg.sv
package htm_pkg;

    localparam int HDR_W   = 24;
    localparam int GAIN_W  = 12;
    localparam int OUT_W   = 8;
    localparam int PROD_W  = HDR_W + GAIN_W;
    localparam int THR_W   = PROD_W + 2;
    localparam int LANES   = 3;
    localparam int STEPS   = OUT_W;
    localparam int BIG_W   = 300;
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(256);

    typedef logic [THR_W-1:0] t_thr_tab [1<<OUT_W];

    // Entry k is the smallest product P with k^11 * (P + D)^5 <= 2^88 * P^5.
    // All ones marks a code that no product in range can reach.
    function automatic t_thr_tab thr_table(input int frac_bits);
        t_thr_tab tab;
        logic [BIG_W-1:0] d;
        logic [BIG_W-1:0] s;
        logic [BIG_W-1:0] p;
        logic [BIG_W-1:0] k11;
        logic [BIG_W-1:0] s5;
        logic [BIG_W-1:0] p5;
        logic [THR_W-1:0] lo;
        logic [THR_W-1:0] hi;
        logic [THR_W-1:0] mid;
        d = BIG_W'(1) << (frac_bits + 8);
        tab[0] = '0;
        for (int k = 1; k < (1 << OUT_W); k++) begin
            k11 = BIG_W'(1);
            for (int e = 0; e < 11; e++) begin
                k11 = k11 * BIG_W'(k);
            end
            lo = '0;
            hi = '1;
            for (int it = 0; it < THR_W + 1; it++) begin
                if (lo < hi) begin
                    mid = lo + ((hi - lo) >> 1);
                    p = BIG_W'(mid);
                    s = p + d;
                    s5 = s * s * s * s * s;
                    p5 = p * p * p * p * p;
                    if (k11 * s5 <= (p5 << 88)) begin
                        hi = mid;
                    end else begin
                        lo = mid + THR_W'(1);
                    end
                end
            end
            tab[k] = lo;
        end
        return tab;
    endfunction

endpackage

FILE: design/htm_lane.sv
module htm_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [htm_pkg::HDR_W-1:0]     i_hdr,
    input  logic [htm_pkg::GAIN_W-1:0]    i_gain,
    output logic [htm_pkg::OUT_W-1:0]     o_byte
);

    localparam htm_pkg::t_thr_tab THR = htm_pkg::thr_table(FRAC_BITS);

    logic [htm_pkg::PROD_W-1:0] r_p [htm_pkg::STEPS];
    logic [htm_pkg::OUT_W-1:0]  r_k [htm_pkg::STEPS+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0] <= htm_pkg::PROD_W'(i_hdr) * htm_pkg::PROD_W'(i_gain);
            r_k[0] <= '0;
        end
    end

    for (genvar g = 0; g < htm_pkg::STEPS; g++) begin : g_step
        logic [htm_pkg::OUT_W-1:0] c;
        assign c = r_k[g] | htm_pkg::OUT_W'(1 << (htm_pkg::STEPS - 1 - g));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (htm_pkg::THR_W'(r_p[g]) >= THR[c]) begin
                    r_k[g+1] <= c;
                end else begin
                    r_k[g+1] <= r_k[g];
                end
            end
        end
        if (g < htm_pkg::STEPS - 1) begin : g_pass
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_p[g+1] <= r_p[g];
                end
            end
        end
    end

    assign o_byte = r_k[htm_pkg::STEPS];

endmodule

FILE: design/hdr_tone_map_rgb8_top.sv
// Throughput: one pixel per cycle while the output is not stalled; one
// multiply stage and eight threshold search stages per channel, three
// channel lanes side by side.
// Reset is synchronous and active low; it empties the pipeline and sets the
// exposure gain to 1.0.
module hdr_tone_map_rgb8_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [11:0] i_cfg_wdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [71:0] i_s_tdata,  // hdr_red, hdr_green, hdr_blue
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata   // out_red, out_green, out_blue
);

    localparam int DEPTH = htm_pkg::STEPS + 1;

    logic [htm_pkg::GAIN_W-1:0] r_gain;
    logic [DEPTH-1:0]           r_vld;
    logic                       en;

    assign en = !r_vld[DEPTH-1] || i_m_tready;
    assign o_s_tready = en;
    assign o_m_tvalid = r_vld[DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= htm_pkg::GAIN_RESET;
            r_vld  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_gain <= i_cfg_wdata;
            end
            if (en) begin
                r_vld <= {r_vld[DEPTH-2:0], i_s_tvalid};
            end
        end
    end

    for (genvar l = 0; l < htm_pkg::LANES; l++) begin : g_lane
        htm_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_hdr  (i_s_tdata[l*htm_pkg::HDR_W +: htm_pkg::HDR_W]),
            .i_gain (r_gain),
            .o_byte (o_m_tdata[l*htm_pkg::OUT_W +: htm_pkg::OUT_W])
        );
    end

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid) else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid) else $error("result dropped");

    a_gain_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> r_gain == htm_pkg::GAIN_RESET) else $error("gain reset");

endmodule

FILE: tb/sv/tb.sv
module tb;

    localparam int FRAC = 16;
    localparam int WIDE = 300;
    localparam int HOLD_CYCLES = 200;

    typedef struct packed {
        logic [htm_pkg::OUT_W-1:0] blue;
        logic [htm_pkg::OUT_W-1:0] green;
        logic [htm_pkg::OUT_W-1:0] red;
    } t_rgb8;

    // Keeps the bytes predicted for every accepted request, oldest first.
    class rgb_expect_board;
        t_rgb8 pending[$];
        int errors;
        int requests;
        int pixels;

        function new();
            errors = 0;
            requests = 0;
            pixels = 0;
        endfunction

        function automatic logic [htm_pkg::OUT_W-1:0] tone_byte(
                logic [htm_pkg::HDR_W-1:0] hdr,
                logic [htm_pkg::GAIN_W-1:0] gain);
            logic [WIDE-1:0] prod;
            logic [WIDE-1:0] sum;
            logic [WIDE-1:0] sum5;
            logic [WIDE-1:0] bound;
            logic [WIDE-1:0] code11;
            logic [htm_pkg::OUT_W-1:0] code;
            logic [htm_pkg::OUT_W-1:0] trial;
            prod = WIDE'(hdr) * WIDE'(gain);
            sum = prod + (WIDE'(1) << (FRAC + 8));
            sum5 = sum * sum * sum * sum * sum;
            bound = (prod * prod * prod * prod * prod) << 88;
            code = '0;
            for (int b = htm_pkg::OUT_W - 1; b >= 0; b--) begin
                trial = code | (htm_pkg::OUT_W'(1) << b);
                code11 = WIDE'(1);
                for (int e = 0; e < 11; e++) begin
                    code11 = code11 * WIDE'(trial);
                end
                if (code11 * sum5 <= bound) begin
                    code = trial;
                end
            end
            return code;
        endfunction

        function void note_request(logic [71:0] data, logic [htm_pkg::GAIN_W-1:0] gain);
            t_rgb8 want;
            want.red = tone_byte(data[23:0], gain);
            want.green = tone_byte(data[47:24], gain);
            want.blue = tone_byte(data[71:48], gain);
            pending.push_back(want);
            requests++;
        endfunction

        function void report(string what);
            $display("mismatch: %s", what);
            errors++;
        endfunction

        function void check_pixel(logic [23:0] data);
            t_rgb8 got;
            t_rgb8 want;
            got = data;
            if (pending.size() == 0) begin
                report($sformatf("unexpected pixel %h", data));
                return;
            end
            want = pending.pop_front();
            pixels++;
            if (got.red !== want.red)
                report($sformatf("red %h, wanted %h", got.red, want.red));
            if (got.green !== want.green)
                report($sformatf("green %h, wanted %h", got.green, want.green));
            if (got.blue !== want.blue)
                report($sformatf("blue %h, wanted %h", got.blue, want.blue));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [11:0] i_cfg_wdata;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [71:0] i_s_tdata;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [23:0] o_m_tdata;

    rgb_expect_board board;
    logic [htm_pkg::GAIN_W-1:0] gain_now;
    bit calm;
    int hold_left;
    int gains_used;

    hdr_tone_map_rgb8_top #(.FRAC_BITS(FRAC)) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(8 * 400000);
        $display("CHECKS FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            board.note_request(i_s_tdata, gain_now);
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            board.check_pixel(o_m_tdata);
        end
    end

    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_m_tready = 1'b0;
                hold_left--;
            end else begin
                i_m_tready = calm ? 1'b1 : ($urandom_range(99) >= 33);
            end
        end
    end

    // Starts and ends on a falling edge, so requests can follow back to back.
    task automatic send_pixel(logic [23:0] r, logic [23:0] g, logic [23:0] b);
        while (!calm && $urandom_range(99) < 33) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata = {b, g, r};
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
    endtask

    task automatic drain();
        while (board.pending.size() > 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_gain(logic [htm_pkg::GAIN_W-1:0] gain);
        drain();
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_wdata = gain;
        gain_now = gain;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        gains_used++;
    endtask

    function automatic logic [23:0] rand_hdr();
        int sel;
        sel = $urandom_range(3);
        if (sel == 0) return 24'($urandom);
        if (sel == 1) return 24'($urandom_range(0, 1 << $urandom_range(23)));
        if (sel == 2) return 24'($urandom_range(0, 24'h0200));
        return 24'($urandom_range(24'h00C000, 24'h040000));
    endfunction

    task automatic random_run(int count);
        for (int n = 0; n < count; n++) begin
            send_pixel(rand_hdr(), rand_hdr(), rand_hdr());
        end
    endtask

    initial begin
        board = new();
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        gain_now = htm_pkg::GAIN_RESET;
        calm = 1'b0;
        hold_left = 0;
        gains_used = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset gain first, then an explicit unity write.
        send_pixel(24'h000000, 24'hFFFFFF, 24'h010000);
        send_pixel(24'h000001, 24'h800000, 24'h00FFFF);
        write_gain(12'd256);
        send_pixel(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_pixel(24'h000000, 24'h000000, 24'h000000);
        send_pixel(24'h555555, 24'hAAAAAA, 24'h000100);
        send_pixel(24'hAAAAAA, 24'h555555, 24'h000002);
        send_pixel(24'h000010, 24'h001000, 24'h100000);
        write_gain(12'd0);
        send_pixel(24'hFFFFFF, 24'h123456, 24'h000001);
        send_pixel(24'h000000, 24'h800000, 24'h010000);
        write_gain(12'd4095);
        send_pixel(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_pixel(24'h000001, 24'h000002, 24'h000000);
        send_pixel(24'h000100, 24'h001000, 24'h010000);
        write_gain(12'd1);
        send_pixel(24'h000001, 24'hFFFFFF, 24'h100000);
        send_pixel(24'h000000, 24'h00FFFF, 24'h7FFFFF);
        write_gain(12'hAAA);
        send_pixel(24'h555555, 24'h000001, 24'hFFFFFF);
        write_gain(12'h555);
        send_pixel(24'hAAAAAA, 24'h000001, 24'hFFFFFF);

        write_gain(12'd256);
        random_run(110);
        write_gain(12'd4095);
        random_run(90);
        write_gain(12'd1);
        random_run(60);
        write_gain(12'd0);
        random_run(20);
        write_gain(htm_pkg::GAIN_W'($urandom));
        random_run(90);

        // Stall the output long enough for the pipeline to fill and back up.
        write_gain(htm_pkg::GAIN_W'($urandom_range(64, 1024)));
        calm = 1'b1;
        hold_left = HOLD_CYCLES;
        random_run(60);
        random_run(40);
        calm = 1'b0;
        write_gain(htm_pkg::GAIN_W'($urandom));
        random_run(60);

        drain();
        if (board.pending.size() > 0) begin
            board.report($sformatf("%0d pixels never came out", board.pending.size()));
        end
        $display("Run covered %0d requests and %0d checked pixels over %0d gain writes,",
                 board.requests, board.pixels, gains_used);
        $display("including zero, unity and full-scale gain and a long output stall.");
        if (board.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
